@@ hw/rtl/bba_pkg.sv @@
package bba_pkg;

    localparam int MEM_UNITS_DEF = 1024;
    localparam int FIELD_W       = 11;
    localparam int KW            = 4;
    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 24;

    typedef enum logic [1:0] {
        ST_GRANT = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FREED = 2'd2
    } status_t;

endpackage

@@ hw/rtl/bba_node_ram.sv @@
module bba_node_ram #(
    parameter int AW = 10,
    parameter int DW = 44
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/buddy_block_allocator.sv @@
// Buddy allocator over MEM_UNITS units (power of two, 2 to 1024).
// Input stream: s_tuser selects allocate (0) or free (1); s_tdata carries the
// request size and, for a free, the 1-based first and last unit of the block.
// Output stream: one transfer per request; m_tuser is the status (granted,
// no fitting block, free done), m_tdata the granted 1-based range or zeros.
// The tree lives in one RAM, one row per sibling pair (left/right free-size
// masks of both nodes), read through a registered output.
// An allocate walks down one level per cycle and writes back one row per
// cycle on the way up. A free computes its path without the RAM, then
// rewrites the path bottom-up.
// One request is in flight at a time; s_tready is high only between requests.
// After reset a clearing pass writes every row before the first request is
// taken. A stalled m_tready holds the result in the output register; the next
// request may be taken while it waits, and its result then waits until the
// output register drains.
module buddy_block_allocator #(
    parameter int MEM_UNITS = bba_pkg::MEM_UNITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bba_pkg::IN_DATA_W-1:0]   s_tdata,   // request_size, free_start, free_end
    input  logic                            s_tuser,   // req_type
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bba_pkg::OUT_DATA_W-1:0]  m_tdata,   // grant_start, grant_end
    output logic [1:0]                      m_tuser    // status
);

    localparam int LOG = $clog2(MEM_UNITS);
    localparam int MW  = LOG + 1;
    localparam int AW  = LOG;
    localparam int NW  = LOG + 1;
    localparam int LVW = $clog2(LOG + 1);
    localparam int FW  = bba_pkg::FIELD_W;
    localparam int VW  = bba_pkg::FIELD_W + 1;
    localparam int KW  = bba_pkg::KW;

    typedef logic [3:0][MW-1:0] row_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_AEV,
        S_FDS,
        S_FEX,
        S_FNU,
        S_UP,
        S_FIN
    } state_t;

    state_t                 state_reg;
    logic [AW-1:0]          init_reg;
    logic [MW-1:0]          sz_reg;
    logic [NW-1:0]          n_reg;
    logic [LVW-1:0]         lvl_reg;
    logic [VW-1:0]          lo_reg;
    logic [KW-1:0]          k_reg;
    logic [FW-1:0]          x_reg;
    logic [FW-1:0]          y_reg;
    logic                   free_reg;
    logic [MW-1:0][1:0]     flags_reg;
    logic [NW-1:0]          p_reg;
    logic [LVW-1:0]         plvl_reg;
    row_t                   h_reg;
    bba_pkg::status_t       status_reg;
    logic [FW-1:0]          gs_reg;
    logic [FW-1:0]          ge_reg;
    logic                   m_tvalid_reg;
    logic [bba_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [1:0]             m_tuser_reg;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [4*MW-1:0]        wr_data;
    logic [AW-1:0]          rd_addr;
    logic [4*MW-1:0]        rd_data;
    row_t                   rd_row;
    row_t                   mod_row;

    logic [KW-1:0]          k_calc;
    logic [FW-1:0]          want;
    logic [AW-1:0]          init_inc;

    logic [MW-1:0]          span_w;
    logic [VW-1:0]          span_v;
    logic [VW-1:0]          half_v;
    logic [MW-1:0]          rmask;
    logic [MW-1:0]          ml;
    logic [MW-1:0]          mr;
    logic [MW-1:0]          il;
    logic [MW-1:0]          ir;
    logic                   a_fit;
    logic                   a_take;
    logic                   a_left;

    logic [VW-1:0]          l_v;
    logic [VW-1:0]          r_v;
    logic [VW-1:0]          mid_v;
    logic [VW-1:0]          x_v;
    logic [VW-1:0]          y_v;
    logic                   f_disj;
    logic                   f_exact;
    logic                   f_gl;
    logic                   f_gr;
    logic                   f_left;
    logic                   f_right;

    logic [MW-1:0]          pspan_w;
    logic [MW-1:0]          phalf_w;
    logic                   u_gl;
    logic                   u_gr;
    logic [MW-1:0]          u_l;
    logic [MW-1:0]          u_r;

    bba_node_ram #(
        .AW (AW),
        .DW (4 * MW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_row   = row_t'(rd_data);
    assign want     = s_tdata[FW-1:0];
    assign init_inc = init_reg + AW'(1);

    // ceil(log2(size)), size zero counts as one
    always_comb
    begin
        k_calc = '0;
        for (int i = KW * 3 - 1; i >= 0; i--)
        begin
            if ((VW'(1) << i) >= {1'b0, want})
            begin
                k_calc = KW'(i);
            end
        end
    end

    // allocate: pick the half whose smallest fitting free block is smaller, left on a tie
    always_comb
    begin
        span_w = MW'(1) << lvl_reg;
        span_v = VW'(1) << lvl_reg;
        half_v = span_v >> 1;
        for (int i = 0; i < MW; i++)
        begin
            rmask[i] = (5'(i) >= 5'(k_reg)) && (5'(i) <= 5'(lvl_reg));
        end
        ml     = rd_row[{n_reg[0], 1'b0}] & rmask;
        mr     = rd_row[{n_reg[0], 1'b1}] & rmask;
        il     = ml & (~ml + MW'(1));
        ir     = mr & (~mr + MW'(1));
        a_fit  = (|ml) || (|mr);
        a_take = 5'(k_reg) == 5'(lvl_reg);
        a_left = (|ml) && (!(|mr) || (il <= ir));
    end

    // free: path is set by the range alone
    always_comb
    begin
        x_v     = {1'b0, x_reg};
        y_v     = {1'b0, y_reg};
        l_v     = lo_reg + VW'(1);
        r_v     = lo_reg + span_v;
        mid_v   = lo_reg + half_v;
        f_disj  = (l_v > y_v) || (r_v < x_v);
        f_exact = (l_v == x_v) && (r_v == y_v);
        f_gl    = (l_v <= x_v) && (mid_v >= y_v);
        f_gr    = (mid_v + VW'(1) <= x_v) && (r_v >= y_v);
        f_left  = f_gl && !((l_v > y_v) || (mid_v < x_v)) && (lvl_reg != '0);
        f_right = !f_left && f_gr && !((mid_v + VW'(1) > y_v) || (r_v < x_v))
                  && (lvl_reg != '0);
    end

    // upward recompute of node p from its children row
    always_comb
    begin
        pspan_w = MW'(1) << plvl_reg;
        phalf_w = pspan_w >> 1;
        u_gl    = free_reg ? flags_reg[plvl_reg][1] : 1'b1;
        u_gr    = free_reg ? flags_reg[plvl_reg][0] : 1'b1;
        u_l     = u_gl ? (h_reg[0] | h_reg[1]) : rd_row[{p_reg[0], 1'b0}];
        u_r     = u_gr ? (h_reg[2] | h_reg[3]) : rd_row[{p_reg[0], 1'b1}];
        if (free_reg && (h_reg[0] == phalf_w) && (h_reg[2] == phalf_w))
        begin
            u_l = pspan_w;
            u_r = pspan_w;
        end
    end

    always_comb
    begin
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        mod_row = rd_row;
        unique case (state_reg)
            S_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = init_reg;
                mod_row = {sz_reg, sz_reg, sz_reg, sz_reg};
            end
            S_IDLE:
            begin
                rd_addr = '0;
            end
            S_AEV:
            begin
                if (!a_fit)
                begin
                    rd_addr = AW'(n_reg >> 2);
                end
                else if (a_take)
                begin
                    mod_row[{n_reg[0], 1'b0}] = '0;
                    mod_row[{n_reg[0], 1'b1}] = '0;
                    wr_en   = 1'b1;
                    wr_addr = AW'(n_reg >> 1);
                    rd_addr = AW'(n_reg >> 2);
                end
                else
                begin
                    rd_addr = AW'(n_reg);
                end
            end
            S_FDS:
            begin
                if (f_exact)
                begin
                    rd_addr = AW'(n_reg >> 1);
                end
                else
                begin
                    rd_addr = AW'(n_reg);
                end
            end
            S_FEX:
            begin
                mod_row[{n_reg[0], 1'b0}] = rd_row[{n_reg[0], 1'b0}] | span_w;
                mod_row[{n_reg[0], 1'b1}] = rd_row[{n_reg[0], 1'b1}] | span_w;
                wr_en   = 1'b1;
                wr_addr = AW'(n_reg >> 1);
                rd_addr = AW'(n_reg >> 2);
            end
            S_FNU:
            begin
                rd_addr = AW'(n_reg >> 1);
            end
            S_UP:
            begin
                mod_row[{p_reg[0], 1'b0}] = u_l;
                mod_row[{p_reg[0], 1'b1}] = u_r;
                wr_en   = 1'b1;
                wr_addr = AW'(p_reg >> 1);
                rd_addr = AW'(p_reg >> 2);
            end
            S_FIN:
            begin
                rd_addr = '0;
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
        wr_data = mod_row;
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            init_reg     <= '0;
            sz_reg       <= MW'(MEM_UNITS);
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            // in S_FIN the output register is reloaded instead
            if (m_tvalid_reg && m_tready && (state_reg != S_FIN))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_inc;
                    // row index crosses a power of two: next tree level
                    if ((init_inc & init_reg) == '0)
                    begin
                        sz_reg <= sz_reg >> 1;
                    end
                    if (init_reg == AW'(MEM_UNITS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        n_reg      <= NW'(1);
                        lvl_reg    <= LVW'(LOG);
                        lo_reg     <= '0;
                        k_reg      <= k_calc;
                        x_reg      <= s_tdata[2*FW-1:FW];
                        y_reg      <= s_tdata[3*FW-1:2*FW];
                        free_reg   <= s_tuser;
                        gs_reg     <= '0;
                        ge_reg     <= '0;
                        status_reg <= s_tuser ? bba_pkg::ST_FREED : bba_pkg::ST_GRANT;
                        state_reg  <= s_tuser ? S_FDS : S_AEV;
                    end
                end
                S_AEV:
                begin
                    if (!a_fit || a_take)
                    begin
                        if (!a_fit)
                        begin
                            status_reg <= bba_pkg::ST_NOFIT;
                            h_reg      <= rd_row;
                        end
                        else
                        begin
                            gs_reg <= FW'(lo_reg + VW'(1));
                            ge_reg <= FW'(lo_reg + span_v);
                            h_reg  <= mod_row;
                        end
                        if (n_reg == NW'(1))
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            p_reg     <= n_reg >> 1;
                            plvl_reg  <= lvl_reg + LVW'(1);
                            state_reg <= S_UP;
                        end
                    end
                    else
                    begin
                        n_reg   <= {n_reg[NW-2:0], !a_left};
                        lvl_reg <= lvl_reg - LVW'(1);
                        if (!a_left)
                        begin
                            lo_reg <= lo_reg + half_v;
                        end
                    end
                end
                S_FDS:
                begin
                    if (f_disj)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (f_exact)
                    begin
                        state_reg <= S_FEX;
                    end
                    else
                    begin
                        flags_reg[lvl_reg] <= {f_gl, f_gr};
                        if (f_left || f_right)
                        begin
                            n_reg   <= {n_reg[NW-2:0], f_right};
                            lvl_reg <= lvl_reg - LVW'(1);
                            if (f_right)
                            begin
                                lo_reg <= lo_reg + half_v;
                            end
                        end
                        else
                        begin
                            state_reg <= S_FNU;
                        end
                    end
                end
                S_FEX:
                begin
                    h_reg <= mod_row;
                    if (n_reg == NW'(1))
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        p_reg     <= n_reg >> 1;
                        plvl_reg  <= lvl_reg + LVW'(1);
                        state_reg <= S_UP;
                    end
                end
                S_FNU:
                begin
                    h_reg     <= rd_row;
                    p_reg     <= n_reg;
                    plvl_reg  <= lvl_reg;
                    state_reg <= S_UP;
                end
                S_UP:
                begin
                    h_reg <= mod_row;
                    if (p_reg == NW'(1))
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        p_reg    <= p_reg >> 1;
                        plvl_reg <= plvl_reg + LVW'(1);
                    end
                end
                S_FIN:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, ge_reg, gs_reg};
                        m_tuser_reg  <= status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
